// File: rtl/d2q9bgk_pkg.sv
// Shared types and constants for the D2Q9 BGK cell collision block.
// Holds the beat payload structs, the weight classes and the pipeline depths.
// No dependencies.
package d2q9bgk_pkg;

  localparam int unsigned DIST_W  = 32;
  localparam int unsigned DENS_W  = DIST_W + 4;
  localparam int unsigned OMEGA_W = 15;
  localparam int unsigned NDIR    = 9;
  localparam int unsigned NWT     = 3;

  localparam logic [OMEGA_W-1:0] OMEGA_RESET = 15'd29789;

  // Register stages inside the equilibrium unit and inside one relaxation lane.
  localparam int unsigned EQ_STG = 4;
  localparam int unsigned RX_STG = 3;

  typedef enum logic [1:0] {
    WT_REST,
    WT_AXIS,
    WT_DIAG
  } weight_e;

  typedef struct packed {
    logic signed [DIST_W-1:0] in_rest;
    logic signed [DIST_W-1:0] in_east;
    logic signed [DIST_W-1:0] in_north;
    logic signed [DIST_W-1:0] in_west;
    logic signed [DIST_W-1:0] in_south;
    logic signed [DIST_W-1:0] in_northeast;
    logic signed [DIST_W-1:0] in_northwest;
    logic signed [DIST_W-1:0] in_southwest;
    logic signed [DIST_W-1:0] in_southeast;
  } in_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] out_rest;
    logic signed [DIST_W-1:0] out_east;
    logic signed [DIST_W-1:0] out_north;
    logic signed [DIST_W-1:0] out_west;
    logic signed [DIST_W-1:0] out_south;
    logic signed [DIST_W-1:0] out_northeast;
    logic signed [DIST_W-1:0] out_northwest;
    logic signed [DIST_W-1:0] out_southwest;
    logic signed [DIST_W-1:0] out_southeast;
    logic signed [DENS_W-1:0] cell_density;
    logic                     saturated;
  } out_t;

endpackage

// File: rtl/d2q9bgk_equil.sv
// Equilibrium unit: rounds density times one lattice weight (4/9, 1/9 or 1/36).
// Four register stages; the division by nine is a reciprocal multiply plus one correction.
// Depends on d2q9bgk_pkg.
module d2q9bgk_equil (
  input  logic                                     clk_i,
  input  logic [d2q9bgk_pkg::EQ_STG-1:0]           adv_i,
  input  d2q9bgk_pkg::weight_e                     weight_i,
  input  logic signed [d2q9bgk_pkg::DENS_W-1:0]    rho_i,
  output logic signed [d2q9bgk_pkg::DENS_W-1:0]    feq_o
);

  localparam int unsigned U_W    = 41;
  localparam int unsigned U_SPLIT = 21;
  localparam int unsigned M_W    = 38;
  localparam int unsigned M_SPLIT = 19;
  localparam int unsigned Q_W    = M_W;
  localparam int unsigned PROD_W = U_W + M_W;
  localparam int unsigned R_W    = U_W + 1;
  localparam int unsigned BIAS_SHIFT = 37;

  // floor(2^41 / 9); the truncation error keeps the estimate at most one low.
  localparam logic [M_W-1:0] RECIP   = M_W'((64'd1 << U_W) / 64'd9);
  localparam logic [M_SPLIT-1:0] M_LO = RECIP[M_SPLIT-1:0];
  localparam logic [M_W-M_SPLIT-1:0] M_HI = RECIP[M_W-1:M_SPLIT];
  localparam logic [U_W-1:0] U_BIAS  = U_W'(9) << BIAS_SHIFT;
  localparam logic [Q_W:0]   Q_BIAS  = (Q_W+1)'(1) << BIAS_SHIFT;
  localparam logic [R_W-1:0] DIVISOR = R_W'(9);

  localparam int unsigned PH_W  = U_W - U_SPLIT;
  localparam int unsigned PP11_W = PH_W + M_W - M_SPLIT;
  localparam int unsigned PP10_W = PH_W + M_SPLIT;
  localparam int unsigned PP01_W = U_SPLIT + M_W - M_SPLIT;
  localparam int unsigned PP00_W = U_SPLIT + M_SPLIT;

  logic signed [U_W-1:0] rho_x;
  logic signed [U_W-1:0] num;
  logic [U_W-1:0]        u_d, u_q, ub_q, uc_q;
  logic [PP11_W-1:0]     pp11_d, pp11_q;
  logic [PP10_W-1:0]     pp10_d, pp10_q;
  logic [PP01_W-1:0]     pp01_d, pp01_q;
  logic [PP00_W-1:0]     pp00_d, pp00_q;
  logic [PROD_W-1:0]     prod;
  logic [Q_W-1:0]        q0_d, q0_q, q;
  logic [R_W-1:0]        nine_q0, rem;
  logic [Q_W:0]          q_ext;
  logic signed [d2q9bgk_pkg::DENS_W-1:0] feq_d, feq_q;

  // Rounded rho*k/D with ties up reduces to floor(n/9) with:
  // rest n = 4*rho + 4, axis n = rho + 4, diagonal n = floor((rho + 18) / 4).
  always_comb begin
    rho_x = U_W'(rho_i);
    case (weight_i)
      d2q9bgk_pkg::WT_REST: num = (rho_x <<< 2) + U_W'(4);
      d2q9bgk_pkg::WT_AXIS: num = rho_x + U_W'(4);
      d2q9bgk_pkg::WT_DIAG: num = (rho_x + U_W'(18)) >>> 2;
      default:              num = rho_x + U_W'(4);
    endcase
    // A bias of 9 * 2^37 makes the dividend non-negative without moving the quotient grid.
    u_d = $unsigned(num) + U_BIAS;
  end

  always_comb begin
    pp11_d = PP11_W'(u_q[U_W-1:U_SPLIT]) * PP11_W'(M_HI);
    pp10_d = PP10_W'(u_q[U_W-1:U_SPLIT]) * PP10_W'(M_LO);
    pp01_d = PP01_W'(u_q[U_SPLIT-1:0]) * PP01_W'(M_HI);
    pp00_d = PP00_W'(u_q[U_SPLIT-1:0]) * PP00_W'(M_LO);
  end

  always_comb begin
    prod = (PROD_W'(pp11_q) << (U_SPLIT + M_SPLIT))
         + (PROD_W'(pp10_q) << U_SPLIT)
         + (PROD_W'(pp01_q) << M_SPLIT)
         + PROD_W'(pp00_q);
    q0_d = prod[PROD_W-1:U_W];
  end

  always_comb begin
    nine_q0 = (R_W'(q0_q) << 3) + R_W'(q0_q);
    rem     = R_W'(uc_q) - nine_q0;
    q       = q0_q + Q_W'(rem >= DIVISOR);
    q_ext   = {1'b0, q} - Q_BIAS;
    feq_d   = d2q9bgk_pkg::DENS_W'(q_ext);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      u_q <= u_d;
    end
    if (adv_i[1]) begin
      pp11_q <= pp11_d;
      pp10_q <= pp10_d;
      pp01_q <= pp01_d;
      pp00_q <= pp00_d;
      ub_q   <= u_q;
    end
    if (adv_i[2]) begin
      q0_q <= q0_d;
      uc_q <= ub_q;
    end
    if (adv_i[3]) begin
      feq_q <= feq_d;
    end
  end

  assign feq_o = feq_q;

endmodule

// File: rtl/d2q9bgk_relax.sv
// One relaxation lane: out = f + round(omega * (feq - f)), saturated to the distribution range.
// Three register stages: difference, multiply, round and clip.
// Depends on d2q9bgk_pkg.
module d2q9bgk_relax (
  input  logic                                     clk_i,
  input  logic [d2q9bgk_pkg::RX_STG-1:0]           adv_i,
  input  logic [d2q9bgk_pkg::OMEGA_W-1:0]          omega_i,
  input  logic signed [d2q9bgk_pkg::DIST_W-1:0]    f_i,
  input  logic signed [d2q9bgk_pkg::DENS_W-1:0]    feq_i,
  output logic signed [d2q9bgk_pkg::DIST_W-1:0]    res_o,
  output logic                                     sat_o
);

  localparam int unsigned DIST_W = d2q9bgk_pkg::DIST_W;
  localparam int unsigned DIFF_W = d2q9bgk_pkg::DENS_W;
  localparam int unsigned OM_FRAC = 14;
  localparam int unsigned PROD_W = DIFF_W + d2q9bgk_pkg::OMEGA_W + 1;
  localparam int unsigned DELTA_W = PROD_W - OM_FRAC;
  localparam int unsigned SUM_W = DELTA_W + 1;

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (OM_FRAC - 1);

  logic signed [DIFF_W-1:0]  diff_d, diff_q;
  logic signed [DIST_W-1:0]  fa_q, fb_q;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [DELTA_W-1:0] delta;
  logic signed [SUM_W-1:0]   sum;
  logic signed [DIST_W-1:0]  res_d, res_q;
  logic                      sat_d, sat_q;

  assign diff_d = feq_i - DIFF_W'(f_i);
  assign prod_d = PROD_W'(diff_q) * PROD_W'($signed({1'b0, omega_i}));

  always_comb begin
    // Adding half an LSB before the arithmetic shift rounds ties toward plus infinity.
    delta = DELTA_W'((prod_q + HALF_LSB) >>> OM_FRAC);
    sum   = SUM_W'(fb_q) + SUM_W'(delta);
    if (sum > SUM_W'(DIST_MAX)) begin
      res_d = DIST_MAX;
      sat_d = 1'b1;
    end else if (sum < SUM_W'(DIST_MIN)) begin
      res_d = DIST_MIN;
      sat_d = 1'b1;
    end else begin
      res_d = DIST_W'(sum);
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      diff_q <= diff_d;
      fa_q   <= f_i;
    end
    if (adv_i[1]) begin
      prod_q <= prod_d;
      fb_q   <= fa_q;
    end
    if (adv_i[2]) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

// File: rtl/d2q9_bgk_cell_collision.sv
// D2Q9 BGK collision for one lattice cell with zero momentum.
// Input channel: in_valid_i / in_stall_o carry one cell per beat, nine signed
// distributions. Output channel: out_valid_o / out_stall_i carry the nine
// post-collision distributions, the exact density and a per-beat saturation flag.
// A beat moves at a rising edge where valid is high and stall is low.
// Each accepted cell passes every register stage in order; one cell per cycle
// is taken and delivered when the receiver does not stall. The depth is ten register
// stages: the density adder tree (2 stages), the equilibrium divide-by-nine unit
// (4 stages), the relaxation multiply lanes (3 stages) and the output register.
// Each pipeline stage advances when it is empty or when the stage after it moves,
// so a stalled receiver first lets the empty stages fill, then in_stall_o rises.
// Reset empties the pipeline and sets omega to 29789 (about 1/0.55 in Q1.14).
// cfg_we_i writes the relaxation rate; write it only while no beat is in flight.
// Depends on d2q9bgk_pkg, d2q9bgk_equil and d2q9bgk_relax.
module d2q9_bgk_cell_collision (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  d2q9bgk_pkg::in_t                      in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output d2q9bgk_pkg::out_t                     out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [d2q9bgk_pkg::OMEGA_W-1:0]       cfg_wdata_i
);

  localparam int unsigned DIST_W = d2q9bgk_pkg::DIST_W;
  localparam int unsigned DENS_W = d2q9bgk_pkg::DENS_W;
  localparam int unsigned NDIR   = d2q9bgk_pkg::NDIR;
  localparam int unsigned NWT    = d2q9bgk_pkg::NWT;
  localparam int unsigned NGRP   = 3;
  localparam int unsigned GRP_SZ = NDIR / NGRP;
  localparam int unsigned PSUM_W = DIST_W + 2;
  localparam int unsigned FIRST_DIAG = 5;

  localparam int unsigned S_RHO = 1;
  localparam int unsigned S_EQ0 = 2;
  localparam int unsigned S_RX0 = S_EQ0 + d2q9bgk_pkg::EQ_STG;
  localparam int unsigned S_OUT = S_RX0 + d2q9bgk_pkg::RX_STG;
  localparam int unsigned NSTG  = S_OUT + 1;
  localparam int unsigned NRHO  = S_OUT - S_RHO;

  logic [d2q9bgk_pkg::OMEGA_W-1:0] omega_q;
  logic [NSTG-1:0]                 valid_d, valid_q, adv;

  logic signed [DIST_W-1:0] fin [NDIR];
  logic signed [DIST_W-1:0] f_q [S_RX0][NDIR];
  logic signed [PSUM_W-1:0] psum_d [NGRP];
  logic signed [PSUM_W-1:0] psum_q [NGRP];
  logic signed [DENS_W-1:0] rho_d;
  logic signed [DENS_W-1:0] rho_q [NRHO];
  logic signed [DENS_W-1:0] feq [NWT];
  logic signed [DIST_W-1:0] res [NDIR];
  logic [NDIR-1:0]          sat;
  d2q9bgk_pkg::out_t        out_d, out_q;

  always_comb begin
    fin[0] = in_data_i.in_rest;
    fin[1] = in_data_i.in_east;
    fin[2] = in_data_i.in_north;
    fin[3] = in_data_i.in_west;
    fin[4] = in_data_i.in_south;
    fin[5] = in_data_i.in_northeast;
    fin[6] = in_data_i.in_northwest;
    fin[7] = in_data_i.in_southwest;
    fin[8] = in_data_i.in_southeast;
  end

  // Stage advance chain: a stage moves when it is empty or its successor moves.
  always_comb begin
    adv[S_OUT] = !valid_q[S_OUT] || !out_stall_i;
    for (int k = S_OUT - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_comb begin
    valid_d[0] = adv[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NSTG; k++) begin
      valid_d[k] = adv[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      omega_q <= d2q9bgk_pkg::OMEGA_RESET;
    end else begin
      valid_q <= valid_d;
      if (cfg_we_i) begin
        omega_q <= cfg_wdata_i;
      end
    end
  end

  // Density: three partial sums of three, then the final sum.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      psum_d[g] = PSUM_W'(fin[GRP_SZ*g]) + PSUM_W'(fin[GRP_SZ*g+1])
                + PSUM_W'(fin[GRP_SZ*g+2]);
    end
    rho_d = DENS_W'(psum_q[0]) + DENS_W'(psum_q[1]) + DENS_W'(psum_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      f_q[0] <= fin;
      psum_q <= psum_d;
    end
    for (int k = 1; k < S_RX0; k++) begin
      if (adv[k]) begin
        f_q[k] <= f_q[k-1];
      end
    end
    if (adv[S_RHO]) begin
      rho_q[0] <= rho_d;
    end
    for (int k = 1; k < NRHO; k++) begin
      if (adv[S_RHO+k]) begin
        rho_q[k] <= rho_q[k-1];
      end
    end
    if (adv[S_OUT]) begin
      out_q <= out_d;
    end
  end

  // One equilibrium unit per weight class, shared by the lanes of that class.
  for (genvar w = 0; w < NWT; w++) begin : g_equil
    d2q9bgk_equil u_equil (
      .clk_i    (clk_i),
      .adv_i    (adv[S_EQ0 +: d2q9bgk_pkg::EQ_STG]),
      .weight_i (d2q9bgk_pkg::weight_e'(w)),
      .rho_i    (rho_q[0]),
      .feq_o    (feq[w])
    );
  end

  for (genvar i = 0; i < NDIR; i++) begin : g_lane
    localparam d2q9bgk_pkg::weight_e LANE_WT =
      (i == 0)          ? d2q9bgk_pkg::WT_REST :
      (i < FIRST_DIAG)  ? d2q9bgk_pkg::WT_AXIS : d2q9bgk_pkg::WT_DIAG;

    d2q9bgk_relax u_relax (
      .clk_i   (clk_i),
      .adv_i   (adv[S_RX0 +: d2q9bgk_pkg::RX_STG]),
      .omega_i (omega_q),
      .f_i     (f_q[S_RX0-1][i]),
      .feq_i   (feq[LANE_WT]),
      .res_o   (res[i]),
      .sat_o   (sat[i])
    );
  end

  // Merge the lane results into one output beat.
  always_comb begin
    out_d.out_rest      = res[0];
    out_d.out_east      = res[1];
    out_d.out_north     = res[2];
    out_d.out_west      = res[3];
    out_d.out_south     = res[4];
    out_d.out_northeast = res[5];
    out_d.out_northwest = res[6];
    out_d.out_southwest = res[7];
    out_d.out_southeast = res[8];
    out_d.cell_density  = rho_q[NRHO-1];
    out_d.saturated     = |sat;
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = valid_q[S_OUT];
  assign out_data_o  = out_q;

endmodule

// File: tb/d2q9_bgk_cell_collision_check.sv
// Checker for the D2Q9 BGK cell collision block: watches both beat channels and the omega port.
// Predicts each output beat from the accepted input beat and compares it field by field.
// Depends on d2q9bgk_pkg.
`timescale 1ns / 1ps

module d2q9_bgk_cell_collision_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  d2q9bgk_pkg::in_t                in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  d2q9bgk_pkg::out_t               out_data_i,
  input  logic                            cfg_we_i,
  input  logic [d2q9bgk_pkg::OMEGA_W-1:0] cfg_wdata_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  localparam int unsigned DIST_W   = d2q9bgk_pkg::DIST_W;
  localparam int unsigned DENS_W   = d2q9bgk_pkg::DENS_W;
  localparam int unsigned OMEGA_W  = d2q9bgk_pkg::OMEGA_W;
  localparam int unsigned NDIR     = d2q9bgk_pkg::NDIR;
  localparam int unsigned OUT_LSB  = DENS_W + 1;
  localparam longint      DIST_MAX = (longint'(1) <<< (DIST_W - 1)) - 1;
  localparam longint      DIST_MIN = -DIST_MAX - 1;
  localparam longint      Q14_HALF = longint'(1) <<< 13;

  d2q9bgk_pkg::out_t       collided_cells [$];
  logic [OMEGA_W-1:0]      omega_q14;
  d2q9bgk_pkg::out_t       want_cell;
  logic [$bits(d2q9bgk_pkg::out_t)-1:0] want_bits;
  logic [$bits(d2q9bgk_pkg::out_t)-1:0] got_bits;

  string dir_name [NDIR] = '{"out_rest", "out_east", "out_north", "out_west", "out_south",
                             "out_northeast", "out_northwest", "out_southwest",
                             "out_southeast"};

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic d2q9bgk_pkg::weight_e weight_of(int dir);
    if (dir == 0) return d2q9bgk_pkg::WT_REST;
    if (dir < 5) return d2q9bgk_pkg::WT_AXIS;
    return d2q9bgk_pkg::WT_DIAG;
  endfunction

  // Zero-momentum BGK relaxation of one cell, with exact rounding of both divisions.
  function automatic d2q9bgk_pkg::out_t collide_cell(d2q9bgk_pkg::in_t cell_beat,
                                                     logic [OMEGA_W-1:0] om);
    logic [$bits(d2q9bgk_pkg::in_t)-1:0]  iv;
    logic [$bits(d2q9bgk_pkg::out_t)-1:0] ov;
    longint                  f [NDIR];
    longint                  rho;
    longint                  num;
    longint                  den;
    longint                  n;
    longint                  feq;
    longint                  prod;
    longint                  r;
    bit                      clipped;
    iv      = cell_beat;
    ov      = '0;
    rho     = 0;
    clipped = 1'b0;
    for (int i = 0; i < NDIR; i++) begin
      f[i] = longint'($signed(iv[(NDIR-1-i)*DIST_W +: DIST_W]));
      rho  = rho + f[i];
    end
    for (int i = 0; i < NDIR; i++) begin
      case (weight_of(i))
        d2q9bgk_pkg::WT_REST: begin
          num = 4;
          den = 9;
        end
        d2q9bgk_pkg::WT_AXIS: begin
          num = 1;
          den = 9;
        end
        default: begin
          num = 1;
          den = 36;
        end
      endcase
      // Round half up: floor((2*rho*num + den) / (2*den)).
      n   = 2 * rho * num + den;
      feq = n / (2 * den);
      if ((n % (2 * den)) != 0 && n < 0) feq = feq - 1;
      prod = (feq - f[i]) * longint'(om);
      r    = f[i] + ((prod + Q14_HALF) >>> 14);
      if (r > DIST_MAX) begin
        r       = DIST_MAX;
        clipped = 1'b1;
      end else if (r < DIST_MIN) begin
        r       = DIST_MIN;
        clipped = 1'b1;
      end
      ov[OUT_LSB + (NDIR-1-i)*DIST_W +: DIST_W] = r[DIST_W-1:0];
    end
    ov[DENS_W:1] = rho[DENS_W-1:0];
    ov[0]        = clipped;
    return d2q9bgk_pkg::out_t'(ov);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omega_q14 = d2q9bgk_pkg::OMEGA_RESET;
      collided_cells.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (collided_cells.size() == 0) begin
          $error("output beat with no cell pending");
          fail_count_o++;
        end else begin
          want_cell = collided_cells.pop_front();
          want_bits = want_cell;
          got_bits  = out_data_i;
          for (int i = 0; i < NDIR; i++) begin
            if (got_bits[OUT_LSB + (NDIR-1-i)*DIST_W +: DIST_W] !==
                want_bits[OUT_LSB + (NDIR-1-i)*DIST_W +: DIST_W]) begin
              $error("%s: expected %0d, actual %0d", dir_name[i],
                     $signed(want_bits[OUT_LSB + (NDIR-1-i)*DIST_W +: DIST_W]),
                     $signed(got_bits[OUT_LSB + (NDIR-1-i)*DIST_W +: DIST_W]));
              fail_count_o++;
            end
          end
          if (out_data_i.cell_density !== want_cell.cell_density) begin
            $error("cell_density: expected %0d, actual %0d", want_cell.cell_density,
                   out_data_i.cell_density);
            fail_count_o++;
          end
          if (out_data_i.saturated !== want_cell.saturated) begin
            $error("saturated: expected %0b, actual %0b", want_cell.saturated,
                   out_data_i.saturated);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) collided_cells.push_back(collide_cell(in_data_i, omega_q14));
      if (cfg_we_i) omega_q14 = cfg_wdata_i;
    end
    pending_o = collided_cells.size();
  end

endmodule

// File: tb/d2q9_bgk_cell_collision_test.sv
// Top of the D2Q9 BGK cell collision testbench: clock, reset, cell stimulus and omega writes.
// Instantiates the block and its checker side by side and reports the verdict.
// Depends on d2q9bgk_pkg, d2q9_bgk_cell_collision and d2q9_bgk_cell_collision_check.
`timescale 1ns / 1ps

module d2q9_bgk_cell_collision_test;

  typedef enum int {
    MIX_LATTICE,
    MIX_FULL,
    MIX_CORNER,
    MIX_WIDE
  } cell_mix_e;

  localparam int unsigned       DIST_W    = d2q9bgk_pkg::DIST_W;
  localparam int unsigned       OMEGA_W   = d2q9bgk_pkg::OMEGA_W;
  localparam int unsigned       NDIR      = d2q9bgk_pkg::NDIR;
  localparam logic [DIST_W-1:0] DIST_MAX  = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W-1:0] DIST_MIN  = {1'b1, {(DIST_W-1){1'b0}}};
  localparam logic [DIST_W-1:0] DIST_ONE  = 32'h0800_0000;
  localparam int                SEG_CELLS = 256;
  localparam int                SEGMENTS  = 7;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  d2q9bgk_pkg::in_t   in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  d2q9bgk_pkg::out_t  out_data;
  logic               cfg_we    = 1'b0;
  logic [OMEGA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  d2q9_bgk_cell_collision dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  d2q9_bgk_cell_collision_check checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    #(5_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic d2q9bgk_pkg::in_t make_cell(logic [DIST_W-1:0] rest,
                                                 logic [DIST_W-1:0] east,
                                                 logic [DIST_W-1:0] north,
                                                 logic [DIST_W-1:0] west,
                                                 logic [DIST_W-1:0] south,
                                                 logic [DIST_W-1:0] ne,
                                                 logic [DIST_W-1:0] nw,
                                                 logic [DIST_W-1:0] sw,
                                                 logic [DIST_W-1:0] se);
    return d2q9bgk_pkg::in_t'({rest, east, north, west, south, ne, nw, sw, se});
  endfunction

  function automatic logic [DIST_W-1:0] random_dist(cell_mix_e mix);
    case (mix)
      MIX_LATTICE: return $urandom_range(0, 32'h0400_0000);
      MIX_FULL:    return $urandom();
      MIX_WIDE:    return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
      default: begin
        case ($urandom_range(5))
          0:       return DIST_MAX;
          1:       return DIST_MIN;
          2:       return '0;
          3:       return '1;
          4:       return 1;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  function automatic d2q9bgk_pkg::in_t random_cell();
    logic [$bits(d2q9bgk_pkg::in_t)-1:0] bits;
    int                     pick;
    cell_mix_e              mix;
    pick = $urandom_range(99);
    if (pick < 45) mix = MIX_LATTICE;
    else if (pick < 65) mix = MIX_FULL;
    else if (pick < 80) mix = MIX_CORNER;
    else mix = MIX_WIDE;
    for (int i = 0; i < NDIR; i++) bits[i*DIST_W +: DIST_W] = random_dist(mix);
    return d2q9bgk_pkg::in_t'(bits);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_cell(input d2q9bgk_pkg::in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_cells();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_omega(input logic [OMEGA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 63;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 63;
      end
      default: begin
        send_idle_pct  = 22;
        recv_stall_pct = 22;
      end
    endcase
  endtask

  initial begin
    int                 waited;
    int                 fails;
    logic [OMEGA_W-1:0] omega_value;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed cells at the reset relaxation rate.
    send_cell(make_cell('0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_cell(make_cell(DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX,
                        DIST_MAX, DIST_MAX));
    send_cell(make_cell(DIST_MIN, DIST_MIN, DIST_MIN, DIST_MIN, DIST_MIN, DIST_MIN, DIST_MIN,
                        DIST_MIN, DIST_MIN));
    send_cell(make_cell('1, '1, '1, '1, '1, '1, '1, '1, '1));
    // A cell already at equilibrium should come out unchanged.
    send_cell(make_cell(32'h0400_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
                        32'h0100_0000, 32'h0040_0000, 32'h0040_0000, 32'h0040_0000,
                        32'h0040_0000));
    send_cell(make_cell(DIST_ONE, '0, '0, '0, '0, '0, '0, '0, '0));
    send_cell(make_cell('0, '0, '0, '0, '0, DIST_ONE, '0, '0, '0));
    // Zero density made of large opposing values.
    send_cell(make_cell('0, 32'h4000_0000, DIST_MAX, 32'hC000_0000, DIST_MIN + 1, 32'h1234_5678,
                        '0, 32'hEDCB_A988, '0));
    send_cell(make_cell(-DIST_ONE, -DIST_ONE, -DIST_ONE, -DIST_ONE, -DIST_ONE, -DIST_ONE,
                        -DIST_ONE, -DIST_ONE, -DIST_ONE));
    send_cell(make_cell(DIST_MAX, DIST_MIN, DIST_MAX, DIST_MIN, DIST_MAX, DIST_MIN, DIST_MAX,
                        DIST_MIN, DIST_MAX));
    send_cell(make_cell(DIST_MIN, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX,
                        DIST_MAX, DIST_MAX));
    send_cell(make_cell(1, 1, 1, 1, 1, 1, 1, 1, 1));
    send_cell(make_cell(1, '1, 1, '1, 1, '1, 1, '1, 1));
    send_cell(random_cell());
    drain_cells();

    // The largest omega, just below the stable limit of two.
    write_omega('1);
    send_cell(make_cell(DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX,
                        DIST_MAX, DIST_MAX));
    send_cell(make_cell(DIST_MIN, DIST_MIN, DIST_MIN, DIST_MIN, DIST_MIN, DIST_MIN, DIST_MIN,
                        DIST_MIN, DIST_MIN));
    send_cell(make_cell(DIST_ONE, '0, '0, '0, '0, '0, '0, '0, '0));
    send_cell(make_cell('0, DIST_MAX, '0, DIST_MIN, '0, DIST_MAX, '0, DIST_MIN, '0));
    drain_cells();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0:       omega_value = '0;
        1:       omega_value = '1;
        2:       omega_value = 15'd16384;
        3:       omega_value = 15'd1;
        6:       omega_value = d2q9bgk_pkg::OMEGA_RESET;
        default: omega_value = OMEGA_W'($urandom_range(32767));
      endcase
      write_omega(omega_value);
      set_idling(seg);
      for (int n = 0; n < SEG_CELLS; n++) send_cell(random_cell());
      drain_cells();
    end

    set_idling(0);
    waited = 0;
    while (pending != 0 && waited < 10000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
    fails = fail_count;
    if (pending != 0) begin
      $error("%0d predicted cells never came out", pending);
      fails++;
    end
    if (fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
